// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define SLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/slm_pkg.sv
// Package: types, codes and constants of the sorted list merge block.
`timescale 1ns / 1ps

package slm_pkg;

  localparam int DATA_W             = 32;
  localparam int MODE_W             = 2;
  localparam int DEFAULT_LIST_DEPTH = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [MODE_W-1:0]        mode_t;

  // Command codes carried in the mode field
  localparam mode_t MODE_LOAD_FIRST  = 2'd0;
  localparam mode_t MODE_LOAD_SECOND = 2'd1;
  localparam mode_t MODE_MERGE       = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic step;
  } slm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lists_empty;
    logic step_last;
  } slm_status_t;

endpackage

// File: hdl/slm_if.sv
// Interfaces: input command channel and merged result channel.
`timescale 1ns / 1ps

interface slm_in_if;
  import slm_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slm_out_if;
  import slm_pkg::*;
  logic  valid;
  logic  ready;
  word_t merged_value;
  logic  from_second;
  logic  last_flag;

  modport source (output valid, output merged_value, output from_second,
                  output last_flag, input ready);
  modport sink   (input valid, input merged_value, input from_second,
                  input last_flag, output ready);
endinterface

// File: hdl/slm_datapath.sv
// Datapath: two list memories, counts, read pointers, head compare, result register.
`timescale 1ns / 1ps

module slm_datapath
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  slm_cmd_t    cmd,
  input  word_t       in_value,
  output slm_status_t status,
  output word_t       merged_value,
  output logic        from_second,
  output logic        last_flag
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  word_t first_mem  [LIST_DEPTH];
  word_t second_mem [LIST_DEPTH];

  logic [CW-1:0] first_cnt_r, first_cnt_nxt;
  logic [CW-1:0] second_cnt_r, second_cnt_nxt;
  logic [CW-1:0] first_idx_r, first_idx_nxt;
  logic [CW-1:0] second_idx_r, second_idx_nxt;
  word_t         first_head_r, second_head_r;
  word_t         merged_value_r;
  logic          from_second_r, last_flag_r;

  logic have_first, have_second, take_first, step_last;
  logic first_wr, second_wr;

  // Head compare and pointer/count update
  always_comb begin
    have_first  = (first_idx_r != first_cnt_r);
    have_second = (second_idx_r != second_cnt_r);
    // ties go to the first list
    take_first  = have_first && (!have_second || (first_head_r <= second_head_r));
    if (take_first) begin
      step_last = ((first_idx_r + ONE_C) == first_cnt_r) && !have_second;
    end else begin
      step_last = !have_first && ((second_idx_r + ONE_C) == second_cnt_r);
    end

    first_wr  = cmd.load_first && (first_cnt_r != DEPTH_C);
    second_wr = cmd.load_second && (second_cnt_r != DEPTH_C);

    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    first_idx_nxt  = first_idx_r;
    second_idx_nxt = second_idx_r;

    if (first_wr) begin
      first_cnt_nxt = first_cnt_r + ONE_C;
    end
    if (second_wr) begin
      second_cnt_nxt = second_cnt_r + ONE_C;
    end
    if (cmd.step) begin
      if (step_last) begin
        first_cnt_nxt  = '0;
        second_cnt_nxt = '0;
        first_idx_nxt  = '0;
        second_idx_nxt = '0;
      end else if (take_first) begin
        first_idx_nxt = first_idx_r + ONE_C;
      end else begin
        second_idx_nxt = second_idx_r + ONE_C;
      end
    end

    status.lists_empty = (first_cnt_r == '0) && (second_cnt_r == '0);
    status.step_last   = step_last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      first_idx_r  <= '0;
      second_idx_r <= '0;
    end else begin
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      first_idx_r  <= first_idx_nxt;
      second_idx_r <= second_idx_nxt;
    end
  end

  // List memories: one write port, one registered read port each.
  // The read address follows the next pointer so the head is ready every cycle.
  always_ff @(posedge clk) begin
    if (first_wr) begin
      first_mem[first_cnt_r[IW-1:0]] <= in_value;
    end
    if (second_wr) begin
      second_mem[second_cnt_r[IW-1:0]] <= in_value;
    end
    first_head_r  <= first_mem[first_idx_nxt[IW-1:0]];
    second_head_r <= second_mem[second_idx_nxt[IW-1:0]];
  end

  // Result register, loaded on each merge step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      merged_value_r <= take_first ? first_head_r : second_head_r;
      from_second_r  <= !take_first;
      last_flag_r    <= step_last;
    end
  end

  assign merged_value = merged_value_r;
  assign from_second  = from_second_r;
  assign last_flag    = last_flag_r;

endmodule

// File: hdl/slm_ctrl.sv
// Controller: command decode, merge sequencing and result valid flag.
`timescale 1ns / 1ps

module slm_ctrl
  import slm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  mode_t       in_mode,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  slm_status_t status,
  output slm_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_LOAD_FIRST:  cmd.load_first  = 1'b1;
            MODE_LOAD_SECOND: cmd.load_second = 1'b1;
            MODE_MERGE: begin
              // nothing to emit when both lists are empty
              if (!status.lists_empty) begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        // one element per cycle while the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.step      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.step_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/sorted_list_merge_core.sv
// Loads are accepted back to back; a load into a full list is dropped. A merge
// command blocks the input side until the merge is done: after the command
// one merged element leaves per cycle while the result side does not stall,
// paced by the single head compare and the one read port of each list memory.
// Ties emit the first list's element first, the final element carries
// last_flag, and both lists are empty afterwards. A merge of two empty lists
// gives no result. The list memories are not cleared at reset; no entry beyond
// a list's count is ever emitted.
`timescale 1ns / 1ps

module sorted_list_merge_core
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  slm_in_if.sink     in_ch,
  slm_out_if.source  out_ch
);

  slm_cmd_t    cmd;
  slm_status_t status;

  // Sequencer
  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and compare
  slm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_ch.value),
    .status       (status),
    .merged_value (out_ch.merged_value),
    .from_second  (out_ch.from_second),
    .last_flag    (out_ch.last_flag)
  );

endmodule

// File: hdl/slm_checker.sv
// Checker on the top-level ports of the merge core, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slm_checker
  import slm_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input mode_t in_mode,
  input logic  out_valid,
  input logic  out_ready,
  input word_t merged_value,
  input logic  from_second,
  input logic  last_flag
);

  // A stalled result stays offered
  `SLM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `SLM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(merged_value) && $stable(from_second) && $stable(last_flag), "result changed while stalled")

  // While a merge run is unfinished the input side is blocked
  `SLM_ASSERT_NOW(a_run_blocks_input, out_valid && out_ready && !last_flag, !in_ready, "input open during merge")

  // A load or an ignored code never blocks the input side
  `SLM_ASSERT_NEXT(a_load_keeps_ready, in_valid && in_ready && (in_mode != MODE_MERGE), in_ready, "input blocked after a load")

endmodule

bind sorted_list_merge_core slm_checker u_slm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .merged_value (out_ch.merged_value),
  .from_second  (out_ch.from_second),
  .last_flag    (out_ch.last_flag)
);
